// ===== design/bgwf_pkg.sv =====
// ----------------------------------------------------------------------------
// bgwf_pkg: shared types and constants of the background/window fetcher
// Item layouts, register and kind codes, lcd_control bit positions, video
// memory geometry and the shade-to-RGB565 map.
// ----------------------------------------------------------------------------
`default_nettype none

package bgwf_pkg;

  localparam int unsigned VRAM_BYTES = 8192;
  localparam int unsigned VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int unsigned BANK_DEPTH = VRAM_BYTES / 2;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [VRAM_AW-1:0] MAP_BASE_LO      = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_BASE_HI      = 13'h1C00;
  localparam logic [VRAM_AW-1:0] TILE_SIGNED_BASE = 13'h1000;

  localparam int unsigned LCDC_BG_EN     = 0;
  localparam int unsigned LCDC_BG_MAP    = 3;
  localparam int unsigned LCDC_DATA_MODE = 4;
  localparam int unsigned LCDC_WIN_EN    = 5;
  localparam int unsigned LCDC_WIN_MAP   = 6;

  localparam logic [7:0] LCDC_RESET    = 8'd145;
  localparam logic [7:0] PALETTE_RESET = 8'd252;

  localparam logic [15:0] RGB_SHADE0 = 16'hFFFF;
  localparam logic [15:0] RGB_SHADE1 =
      16'(((170 / 8) << 11) | ((170 / 4) << 5) | (170 / 8));
  localparam logic [15:0] RGB_SHADE2 =
      16'(((88 / 8) << 11) | ((88 / 4) << 5) | (88 / 8));
  localparam logic [15:0] RGB_SHADE3 = 16'h0000;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_LCD_CONTROL = 3'd0,
    REG_SCROLL_X    = 3'd1,
    REG_SCROLL_Y    = 3'd2,
    REG_WINDOW_X    = 3'd3,
    REG_WINDOW_Y    = 3'd4,
    REG_BG_PALETTE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] vram_address;
    logic [7:0]  vram_byte;
    logic [7:0]  line_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pixel_column;
    logic [7:0]  pixel_line;
    logic [1:0]  shade;
    logic [15:0] rgb565;
    logic        run_last;
    logic        line_done;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_write_t;

  // One fetch in flight between the map read and the tile-row read.
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] line;
    logic [2:0] first;
    logic [2:0] cnt_m1;
    logic       done;
    logic [2:0] pix_y;
    logic       map_odd;
  } fetch_t;

  // One run handed to the pixel emitter.
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] col;
    logic [7:0] line;
    logic [2:0] first;
    logic [2:0] cnt_m1;
    logic       done;
  } run_t;

  function automatic logic [15:0] shade_rgb(logic [1:0] shade);
    logic [15:0] rgb;
    case (shade)
      2'd0:    rgb = RGB_SHADE0;
      2'd1:    rgb = RGB_SHADE1;
      2'd2:    rgb = RGB_SHADE2;
      default: rgb = RGB_SHADE3;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ===== design/bgwf_chan_if.sv =====
// ----------------------------------------------------------------------------
// bgwf_chan_if: valid/ready channel
// Carries one payload of type T per beat from a source to a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgwf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bgwf_ram.sv =====
// ----------------------------------------------------------------------------
// bgwf_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds while
// no read is requested. A read of the address being written returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bgwf_emit.sv =====
// ----------------------------------------------------------------------------
// bgwf_emit: pixel run emitter
// Holds one run of tile-row data and sends one shaded pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bgwf_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire bgwf_pkg::run_t run_i,
  input  wire logic           bg_en_i,
  input  wire logic [7:0]     palette_i,
  output      logic           free_o,
  bgwf_chan_if.source         out_o
);

  logic           em_v_q;
  bgwf_pkg::run_t run_q;
  logic [2:0]     k_q;

  logic       beat;
  logic       last;
  logic [2:0] bit_idx;
  logic [2:0] sh;
  logic [1:0] cid;
  logic [1:0] shade;

  assign beat   = em_v_q && out_o.ready;
  assign last   = (k_q == run_q.cnt_m1);
  assign free_o = !em_v_q || (beat && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_v_q <= 1'b0;
      k_q    <= 3'd0;
    end else if (load_i) begin
      em_v_q <= 1'b1;
      k_q    <= 3'd0;
    end else if (beat) begin
      if (last) begin
        em_v_q <= 1'b0;
      end else begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  // Tile bytes hold the leftmost pixel in bit 7.
  always_comb begin
    bit_idx = run_q.first + k_q;
    sh      = 3'd7 - bit_idx;
    cid     = {run_q.hi[sh], run_q.lo[sh]};
    shade   = bg_en_i ? palette_i[{cid, 1'b0} +: 2] : 2'd0;
  end

  assign out_o.valid             = em_v_q;
  assign out_o.data.pixel_column = run_q.col + {5'd0, k_q};
  assign out_o.data.pixel_line   = run_q.line;
  assign out_o.data.shade        = shade;
  assign out_o.data.rgb565       = bgwf_pkg::shade_rgb(shade);
  assign out_o.data.run_last     = last;
  assign out_o.data.line_done    = run_q.done;

endmodule

`default_nettype wire

// ===== design/bg_window_tile_fetch_shade_core.sv =====
// ----------------------------------------------------------------------------
// bg_window_tile_fetch_shade_core: background and window pixel fetcher
// Video memory in two byte banks, a two-read fetch pipeline and an emitter.
// ----------------------------------------------------------------------------
// Usage: in_i takes items of three kinds. A write item stores one byte in the
// internal 8 KiB video memory, a start-line item sets the scanline and clears
// the column and fetch counters, and a fetch item, while the column is on
// screen, produces a run of one to eight pixels on out_o, one pixel per beat,
// the last flagged by run_last. cfg_i writes the six registers and is always
// ready; the user must write it only while the block is idle, and the block
// does not enforce this. A fetch reads the tile map in the cycle it is
// accepted and the two tile bytes from stage 1 (even and odd bank, in
// parallel), and stage 2 loads the run into the emitter. The RAM read ports
// are shared by the map and the tile-row read, so a fetch is taken only with
// stage 1 empty; writes and start-line items go one per cycle while in_i is
// ready. The emitter sends one pixel per cycle while out_o is ready, so the
// run length sets the sustained fetch rate. When out_o stalls with a run in
// stage 2, the fetch pipeline and the RAM reads hold and in_i drops ready.
// Reset restores the register defaults and clears the counters and the
// pipeline; video memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bg_window_tile_fetch_shade_core #(
  parameter int unsigned SCREEN_WIDTH = 160
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bgwf_chan_if.sink   in_i,
  bgwf_chan_if.sink   cfg_i,
  bgwf_chan_if.source out_o
);

  localparam logic [7:0] ScrW = 8'(SCREEN_WIDTH);
  localparam int unsigned BankAw = bgwf_pkg::BANK_AW;

  // Configuration registers.
  logic [7:0] lcdc_q, scx_q, scy_q, wx_q, wy_q, pal_q;
  // Line state.
  logic [7:0] col_q, col_d;
  logic [4:0] fc_q;
  logic [7:0] line_q;
  // Fetch pipeline.
  logic             s1_v_q, s2_v_q;
  bgwf_pkg::fetch_t s1_q, s2_q, f0;

  logic in_acc, fetch_go, is_write, adv, em_free, em_load;
  logic [bgwf_pkg::VRAM_AW-1:0] map_addr, row_addr, tile_base;
  logic [7:0] rd0, rd1, tile_id;
  logic re0, re1;
  logic [BankAw-1:0] raddr;
  bgwf_pkg::run_t run;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= bgwf_pkg::LCDC_RESET;
      scx_q  <= 8'd0;
      scy_q  <= 8'd0;
      wx_q   <= 8'd0;
      wy_q   <= 8'd0;
      pal_q  <= bgwf_pkg::PALETTE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        bgwf_pkg::REG_LCD_CONTROL: lcdc_q <= cfg_i.data.value;
        bgwf_pkg::REG_SCROLL_X:    scx_q  <= cfg_i.data.value;
        bgwf_pkg::REG_SCROLL_Y:    scy_q  <= cfg_i.data.value;
        bgwf_pkg::REG_WINDOW_X:    wx_q   <= cfg_i.data.value;
        bgwf_pkg::REG_WINDOW_Y:    wy_q   <= cfg_i.data.value;
        bgwf_pkg::REG_BG_PALETTE:  pal_q  <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input acceptance and fetch planning
  // --------------------------------------------------------------------------
  assign adv        = !s2_v_q || em_free;
  assign in_i.ready = adv && !s1_v_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_write   = in_acc && (in_i.data.kind == bgwf_pkg::KIND_WRITE);
  assign fetch_go   = in_acc && (in_i.data.kind == bgwf_pkg::KIND_FETCH) &&
                      (col_q < ScrW);

  always_comb begin
    logic       bg_en, win_on, in_win, map_sel;
    logic [8:0] col7, sy, room_win;
    logic [7:0] dy, room_scr;
    logic [4:0] tile_x, tile_y;
    logic [2:0] pix_y, first;
    logic [3:0] cnt;

    bg_en  = lcdc_q[bgwf_pkg::LCDC_BG_EN];
    win_on = lcdc_q[bgwf_pkg::LCDC_WIN_EN] && (line_q >= wy_q);
    col7   = {1'b0, col_q} + 9'd7;
    in_win = win_on && (col7 >= {1'b0, wx_q});
    dy     = line_q - wy_q;
    sy     = {1'b0, scy_q} + {1'b0, line_q};
    room_win = {1'b0, wx_q} - 9'd7 - {1'b0, col_q};

    if (in_win) begin
      map_sel = lcdc_q[bgwf_pkg::LCDC_WIN_MAP];
      tile_x  = 5'((col7 - {1'b0, wx_q}) >> 3);
      tile_y  = dy[7:3];
      pix_y   = dy[2:0];
      first   = 3'd0;
    end else begin
      map_sel = lcdc_q[bgwf_pkg::LCDC_BG_MAP];
      tile_x  = scx_q[7:3] + fc_q;
      tile_y  = sy[7:3];
      pix_y   = sy[2:0];
      first   = scx_q[2:0] + col_q[2:0];
    end

    // With the background enabled, background runs end at the tile end or where the window starts.
    if (bg_en && !in_win) begin
      cnt = 4'd8 - {1'b0, first};
      if (win_on && ({5'd0, cnt} > room_win)) begin
        cnt = room_win[3:0];
      end
    end else begin
      cnt = 4'd8;
    end

    room_scr = ScrW - col_q;
    if ({4'd0, cnt} > room_scr) begin
      cnt = room_scr[3:0];
    end

    map_addr = (map_sel ? bgwf_pkg::MAP_BASE_HI : bgwf_pkg::MAP_BASE_LO) |
               {3'd0, tile_y, tile_x};
    col_d    = col_q + {4'd0, cnt};

    f0.col     = col_q;
    f0.line    = line_q;
    f0.first   = first;
    f0.cnt_m1  = 3'(cnt - 4'd1);
    f0.done    = ({1'b0, col_q} + {5'd0, cnt}) >= {1'b0, ScrW};
    f0.pix_y   = pix_y;
    f0.map_odd = map_addr[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 8'd0;
      fc_q   <= 5'd0;
      line_q <= 8'd0;
    end else if (in_acc && (in_i.data.kind == bgwf_pkg::KIND_START)) begin
      line_q <= in_i.data.line_number;
      col_q  <= 8'd0;
      fc_q   <= 5'd0;
    end else if (fetch_go) begin
      col_q <= col_d;
      fc_q  <= fc_q + 5'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Fetch pipeline: map read at acceptance, tile-row read from stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= fetch_go;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= f0;
      s2_q <= s1_q;
    end
  end

  // Unsigned mode indexes from the memory start; signed mode centers on the
  // signed base, with ids 128..255 falling below it.
  always_comb begin
    tile_id = s1_q.map_odd ? rd1 : rd0;
    if (lcdc_q[bgwf_pkg::LCDC_DATA_MODE] || tile_id[7]) begin
      tile_base = '0;
    end else begin
      tile_base = bgwf_pkg::TILE_SIGNED_BASE;
    end
    row_addr = tile_base + {1'b0, tile_id, 4'd0} + {9'd0, s1_q.pix_y, 1'b0};
  end

  // Reads only move when the pipeline moves, so a stalled stage keeps its data
  // on the RAM outputs. Map and tile reads never meet: a fetch is accepted only
  // with stage 1 empty.
  assign re0   = (fetch_go && !map_addr[0]) || (s1_v_q && adv);
  assign re1   = (fetch_go && map_addr[0]) || (s1_v_q && adv);
  assign raddr = fetch_go ? map_addr[bgwf_pkg::VRAM_AW-1:1]
                          : row_addr[bgwf_pkg::VRAM_AW-1:1];

  bgwf_ram #(
    .WIDTH (8),
    .DEPTH (bgwf_pkg::BANK_DEPTH)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (is_write && !in_i.data.vram_address[0]),
    .waddr_i (in_i.data.vram_address[bgwf_pkg::VRAM_AW-1:1]),
    .wdata_i (in_i.data.vram_byte),
    .re_i    (re0),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  bgwf_ram #(
    .WIDTH (8),
    .DEPTH (bgwf_pkg::BANK_DEPTH)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (is_write && in_i.data.vram_address[0]),
    .waddr_i (in_i.data.vram_address[bgwf_pkg::VRAM_AW-1:1]),
    .wdata_i (in_i.data.vram_byte),
    .re_i    (re1),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  // --------------------------------------------------------------------------
  // Pixel emitter
  // --------------------------------------------------------------------------
  assign em_load = s2_v_q && adv;

  always_comb begin
    run.lo     = rd0;
    run.hi     = rd1;
    run.col    = s2_q.col;
    run.line   = s2_q.line;
    run.first  = s2_q.first;
    run.cnt_m1 = s2_q.cnt_m1;
    run.done   = s2_q.done;
  end

  bgwf_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (em_load),
    .run_i     (run),
    .bg_en_i   (lcdc_q[bgwf_pkg::LCDC_BG_EN]),
    .palette_i (pal_q),
    .free_o    (em_free),
    .out_o     (out_o)
  );

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !adv) |=> (s1_v_q && $stable(s1_q)))
    else $error("stalled fetch left stage 1");

  a_ram_idle_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !adv) |-> !(re0 || re1))
    else $error("RAM read while tile data waits for the emitter");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.data.run_last) |=> out_o.valid)
    else $error("run ended without a last pixel");
`endif

endmodule

`default_nettype wire
